>>> src/otcb_pkg.sv
// shared types and constants for the osd text cursor buffer
package otcb_pkg;

    localparam int unsigned DEF_SCREEN_COLS = 30;
    localparam int unsigned DEF_SCREEN_ROWS = 16;

    // cursor position width, positions wrap at this width
    localparam int unsigned POS_W = 13;

    localparam logic [7:0] CHAR_NEWLINE = 8'hFF;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_BLANK   = 8'h00;
    localparam logic [7:0] END_MARK     = 8'hFF;

    // ntsc pull-up of low panel rows
    localparam logic [3:0] NTSC_ROW_LIMIT = 4'd6;
    localparam logic [3:0] NTSC_ROW_SHIFT = 4'd3;

    typedef enum logic [1:0] {
        MODE_PANEL  = 2'd0,
        MODE_CURSOR = 2'd1,
        MODE_REL    = 2'd2,
        MODE_READ   = 2'd3
    } mode_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic panel;
        logic rel;
        logic put;
        logic load;
    } ctl_cmd_t;

    typedef struct packed {
        logic  clear_last;
        mode_t in_mode;
        logic  out_busy;
    } ctl_sts_t;

endpackage

>>> src/otcb_in_if.sv
// input and output channel interfaces
interface otcb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] col_value;
    logic [7:0] row_value;
    logic [7:0] char_code;

    modport source (output valid, output mode, output col_value, output row_value,
                    output char_code, input ready);
    modport sink (input valid, input mode, input col_value, input row_value,
                  input char_code, output ready);
endinterface

interface otcb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic       last_byte;

    modport source (output valid, output read_byte, output last_byte, input ready);
    modport sink (input valid, input read_byte, input last_byte, output ready);
endinterface

>>> src/otcb_ctrl.sv
// sequencing state machine for the osd text cursor buffer
module otcb_ctrl
    import otcb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  ctl_sts_t sts,
    output ctl_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PANEL,
        S_REL,
        S_PUT,
        S_READ
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    unique case (sts.in_mode)
                        MODE_PANEL:  state_next = S_PANEL;
                        MODE_CURSOR: state_next = S_PUT;
                        MODE_REL:    state_next = S_REL;
                        MODE_READ:   state_next = S_READ;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_PANEL:
            begin
                cmd.panel  = 1'b1;
                state_next = S_IDLE;
            end
            S_REL:
            begin
                cmd.rel    = 1'b1;
                state_next = S_PUT;
            end
            S_PUT:
            begin
                cmd.put    = 1'b1;
                state_next = S_IDLE;
            end
            S_READ:
            begin
                // hold until the output slot can take the beat
                if (!sts.out_busy)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/otcb_dp.sv
// screen store, cursor and readout datapath
module otcb_dp
    import otcb_pkg::*;
#(
    parameter int unsigned SCREEN_COLS = DEF_SCREEN_COLS,
    parameter int unsigned SCREEN_ROWS = DEF_SCREEN_ROWS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic [1:0] in_mode,
    input  logic [7:0] in_col,
    input  logic [7:0] in_row,
    input  logic [7:0] in_char,
    input  logic       out_ready,
    output logic       out_valid,
    output logic [7:0] out_byte,
    output logic       out_last,
    input  ctl_cmd_t   cmd,
    output ctl_sts_t   sts
);

    localparam int unsigned STORE_SIZE = SCREEN_ROWS * SCREEN_COLS + 1;
    localparam int unsigned AW         = $clog2(STORE_SIZE);
    localparam int unsigned MW         = POS_W + 2;
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_SIZE - 1);

    function automatic logic [POS_W-1:0] cell_addr(input logic [7:0] row,
                                                   input logic [7:0] col);
        logic [MW-1:0] prod;
        prod = MW'(row) * MW'(SCREEN_COLS) + MW'(col);
        return prod[POS_W-1:0];
    endfunction

    logic [7:0] mem [STORE_SIZE];
    logic [7:0] rd_data_reg;

    logic             ntsc_reg;
    logic [7:0]       col_reg;
    logic [7:0]       row_reg;
    logic [7:0]       char_reg;
    logic [4:0]       panel_col_reg, panel_col_next;
    logic [7:0]       panel_row_reg, panel_row_next;
    logic [POS_W-1:0] write_pos_reg, write_pos_next;
    logic [AW-1:0]    read_pos_reg, read_pos_next;
    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [3:0]    set_row;
    logic [7:0]    rel_row;
    logic [7:0]    rel_col;
    logic [7:0]    nl_row;
    logic          read_last;

    assign read_last = (read_pos_reg == LAST_ADDR);
    assign rel_row   = panel_row_reg + row_reg;
    assign rel_col   = {3'b000, panel_col_reg} + col_reg;
    assign nl_row    = panel_row_reg + 8'd1;

    always_comb
    begin
        set_row = row_reg[3:0];
        if (ntsc_reg && (set_row > NTSC_ROW_LIMIT))
        begin
            set_row = set_row - NTSC_ROW_SHIFT;
        end
    end

    always_comb
    begin
        panel_col_next = panel_col_reg;
        panel_row_next = panel_row_reg;
        write_pos_next = write_pos_reg;
        read_pos_next  = read_pos_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_waddr      = write_pos_reg[AW-1:0];
        mem_wdata      = CHAR_BLANK;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.clear)
        begin
            mem_we       = 1'b1;
            mem_waddr    = clr_cnt_reg;
            clr_cnt_next = clr_cnt_reg + AW'(1);
        end

        if (cmd.panel)
        begin
            panel_col_next = col_reg[4:0];
            panel_row_next = {4'b0000, set_row};
            write_pos_next = cell_addr({4'b0000, set_row}, {3'b000, col_reg[4:0]});
        end

        if (cmd.rel)
        begin
            write_pos_next = cell_addr(rel_row, rel_col);
        end

        if (cmd.put)
        begin
            if (char_reg == CHAR_NEWLINE)
            begin
                panel_row_next = nl_row;
                write_pos_next = cell_addr(nl_row, {3'b000, panel_col_reg});
            end
            else if (write_pos_reg < POS_W'(STORE_SIZE))
            begin
                mem_we         = 1'b1;
                mem_waddr      = write_pos_reg[AW-1:0];
                mem_wdata      = (char_reg == CHAR_SPACE) ? CHAR_BLANK : char_reg;
                write_pos_next = write_pos_reg + POS_W'(1);
            end
        end

        if (cmd.load)
        begin
            // readout clears the cell it returns
            mem_we         = 1'b1;
            mem_waddr      = read_pos_reg;
            read_pos_next  = read_last ? '0 : read_pos_reg + AW'(1);
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[read_pos_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            col_reg  <= in_col;
            row_reg  <= in_row;
            char_reg <= in_char;
        end
        if (cmd.load)
        begin
            out_byte_reg <= read_last ? END_MARK : rd_data_reg;
            out_last_reg <= read_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ntsc_reg      <= 1'b0;
            panel_col_reg <= '0;
            panel_row_reg <= '0;
            write_pos_reg <= '0;
            read_pos_reg  <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ntsc_reg <= cfg_wdata;
            end
            panel_col_reg <= panel_col_next;
            panel_row_reg <= panel_row_next;
            write_pos_reg <= write_pos_next;
            read_pos_reg  <= read_pos_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign sts.clear_last = (clr_cnt_reg == LAST_ADDR);
    assign sts.in_mode    = mode_t'(in_mode);
    assign sts.out_busy   = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

>>> src/osd_text_cursor_buffer.sv
// osd text cursor buffer top level
// after accept each item runs its own states: panel set, cursor write, offset then write, or readout
// once the output slot is free; one item at a time, ready returns after the item finishes
// throughput is set by the controller sequence and the single write port of the store
// after reset a clearing pass writes all SCREEN_ROWS*SCREEN_COLS+1 cells (481 by
// default), one per cycle, before the first item is taken; config writes always land
module osd_text_cursor_buffer
    import otcb_pkg::*;
#(
    parameter int unsigned SCREEN_COLS = DEF_SCREEN_COLS,
    parameter int unsigned SCREEN_ROWS = DEF_SCREEN_ROWS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    otcb_in_if.sink    in_ch,
    otcb_out_if.source out_ch
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;
    logic     in_ready;

    assign in_ch.ready = in_ready;

    otcb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    otcb_dp #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_mode   (in_ch.mode),
        .in_col    (in_ch.col_value),
        .in_row    (in_ch.row_value),
        .in_char   (in_ch.char_code),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .out_byte  (out_ch.read_byte),
        .out_last  (out_ch.last_byte),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
